// ===== hdl/ipa_pkg.sv =====
package ipa_pkg;

  // Formatting limits
  localparam int MaxChars = 64;
  localparam int CntW     = $clog2(MaxChars + 1);

  // Value and digit buffer geometry
  localparam int ValW      = 64;
  localparam int IterW     = $clog2(ValW);
  localparam int DigitsBin = ValW;
  localparam int DigitsOct = (ValW + 2) / 3;
  localparam int DigitsHex = ValW / 4;
  localparam int DigitsDec = 20;
  localparam int BufW      = 4 * DigitsDec;
  localparam int OctLead   = 3 * DigitsOct - ValW;

  // Command queue depth between front and back
  localparam int QDepth = 2;

  // Radix request codes
  localparam logic [4:0] RadixCodeBin = 5'd2;
  localparam logic [4:0] RadixCodeOct = 5'd8;
  localparam logic [4:0] RadixCodeHex = 5'd16;

  // Characters
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperF = 8'h46;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerF = 8'h66;

  typedef enum logic [1:0] {
    RadixBin,
    RadixOct,
    RadixDec,
    RadixHex
  } radix_e;

  typedef struct packed {
    logic [ValW-1:0]   value;
    logic [4:0]        radix;
    logic              lowercase;
    logic [6:0]        field_width;
    logic signed [7:0] min_digits;
    logic [7:0]        pad_char;
    logic              left_align;
  } item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } result_t;

  // One formatted item, digits left-aligned in the buffer
  typedef struct packed {
    logic [BufW-1:0] digits;
    radix_e          radix;
    logic            lowercase;
    logic [CntW-1:0] num_digits;
    logic [CntW-1:0] num_zeros;
    logic [CntW-1:0] num_spaces;
    logic            left_align;
  } cmd_t;

  function automatic radix_e decode_radix(logic [4:0] code);
    radix_e r;
    unique case (code)
      RadixCodeBin: r = RadixBin;
      RadixCodeOct: r = RadixOct;
      RadixCodeHex: r = RadixHex;
      default:      r = RadixDec;
    endcase
    return r;
  endfunction

  // Most significant digit of a left-aligned buffer
  function automatic logic [3:0] top_digit(logic [BufW-1:0] buf_v, radix_e r);
    logic [3:0] d;
    unique case (r)
      RadixBin: d = {3'b000, buf_v[BufW-1]};
      RadixOct: d = {1'b0, buf_v[BufW-1 -: 3]};
      default:  d = buf_v[BufW-1 -: 4];
    endcase
    return d;
  endfunction

  // Drop the most significant digit
  function automatic logic [BufW-1:0] shift_digit(logic [BufW-1:0] buf_v, radix_e r);
    logic [BufW-1:0] s;
    unique case (r)
      RadixBin: s = buf_v << 1;
      RadixOct: s = buf_v << 3;
      default:  s = buf_v << 4;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] digit_char(logic [3:0] d, logic lc);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = ChZero + {4'b0000, d};
    end else if (lc) begin
      c = ChLowerA + {4'b0000, d - 4'd10};
    end else begin
      c = ChUpperA + {4'b0000, d - 4'd10};
    end
    return c;
  endfunction

endpackage

// ===== hdl/integer_to_padded_ascii_core.sv =====
// Formats one unsigned 64-bit value as printf-style text, one character per
// result beat. An item is taken when start is high and busy is low; busy stays
// high while the front end converts it: decimal runs a BCD shift-and-add over
// the value and then removes leading zero digits, while hex, octal and binary
// skip the conversion and only strip leading zero digits, one digit per cycle.
// A two-entry queue then lets the next item be converted while the back end
// loads and emits the previous one at one character per cycle, up to 64
// characters. When both queue entries are taken, the converted item waits
// in the front end and busy stays high until the back end frees an entry.
// Result beats cannot be held off: each is on the result port for exactly one
// cycle, with last_char set on the final character of an item. An item whose
// text is empty yields no beats at all.
module integer_to_padded_ascii_core import ipa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    result_valid_o,
  output result_t result_o
);

  logic push, full, pop, empty;
  cmd_t push_cmd, head_cmd;

  ipa_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .item_i (item_i),
    .push_o (push),
    .cmd_o  (push_cmd),
    .full_i (full)
  );

  ipa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (head_cmd)
  );

  ipa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .cmd_i          (head_cmd),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== hdl/ipa_front.sv =====
module ipa_front import ipa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  item_t item_i,
  output logic  push_o,
  output cmd_t  cmd_o,
  input  logic  full_i
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StConv = 4'b0010,
    StNorm = 4'b0100,
    StPush = 4'b1000
  } front_state_e;

  front_state_e    state_q, state_d;
  logic [ValW-1:0] val_q, val_d;
  logic [BufW-1:0] buf_q, buf_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic [CntW-1:0] nd_q, nd_d;
  radix_e          radix_q, radix_d;
  logic            lc_q, lc_d;
  logic [CntW-1:0] width_q, width_d;
  logic [CntW-1:0] prec_q, prec_d;
  logic            prec_given_q, prec_given_d;
  logic            zero_pad_q, zero_pad_d;
  logic            left_q, left_d;
  logic            vzero_q, vzero_d;

  logic [BufW-1:0] bcd_adj;
  logic [BufW-1:0] load_buf;
  logic [CntW-1:0] nd_eff, zeros, spaces, body;

  assign busy = (state_q != StIdle);

  // Shift-and-add-3 correction on every BCD digit
  always_comb begin
    for (int i = 0; i < DigitsDec; i++) begin
      if (buf_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = buf_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = buf_q[4*i +: 4];
      end
    end
  end

  assign load_buf = {item_i.value, {(BufW-ValW){1'b0}}};

  // Zero and space counts from the normalized digit count
  always_comb begin
    nd_eff = (prec_given_q && (prec_q == '0) && vzero_q) ? '0 : nd_q;
    zeros  = '0;
    spaces = '0;
    body   = nd_eff;
    if (prec_given_q) begin
      if (prec_q > nd_eff) begin
        zeros = prec_q - nd_eff;
      end
      body = nd_eff + zeros;
      if (width_q > body) begin
        spaces = width_q - body;
      end
    end else if (zero_pad_q) begin
      if (width_q > nd_eff) begin
        zeros = width_q - nd_eff;
      end
    end else begin
      if (width_q > nd_eff) begin
        spaces = width_q - nd_eff;
      end
    end
  end

  always_comb begin
    cmd_o.digits     = buf_q;
    cmd_o.radix      = radix_q;
    cmd_o.lowercase  = lc_q;
    cmd_o.num_digits = nd_eff;
    cmd_o.num_zeros  = zeros;
    cmd_o.num_spaces = spaces;
    cmd_o.left_align = left_q;
  end

  assign push_o = (state_q == StPush) && !full_i;

  // Sequencer: accept, convert (decimal only), normalize, hand over
  always_comb begin
    state_d      = state_q;
    val_d        = val_q;
    buf_d        = buf_q;
    iter_d       = iter_q;
    nd_d         = nd_q;
    radix_d      = radix_q;
    lc_d         = lc_q;
    width_d      = width_q;
    prec_d       = prec_q;
    prec_given_d = prec_given_q;
    zero_pad_d   = zero_pad_q;
    left_d       = left_q;
    vzero_d      = vzero_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          radix_d      = decode_radix(item_i.radix);
          lc_d         = item_i.lowercase;
          width_d      = (item_i.field_width > 7'(MaxChars)) ?
                         CntW'(MaxChars) : CntW'(item_i.field_width);
          prec_given_d = !item_i.min_digits[7];
          prec_d       = (item_i.min_digits[6:0] > 7'(MaxChars)) ?
                         CntW'(MaxChars) : CntW'(item_i.min_digits[6:0]);
          zero_pad_d   = (item_i.pad_char == ChZero);
          left_d       = item_i.left_align;
          vzero_d      = (item_i.value == '0);
          val_d        = item_i.value;
          iter_d       = '0;
          unique case (decode_radix(item_i.radix))
            RadixBin: begin
              buf_d   = load_buf;
              nd_d    = CntW'(DigitsBin);
              state_d = StNorm;
            end
            RadixOct: begin
              buf_d   = load_buf >> OctLead;
              nd_d    = CntW'(DigitsOct);
              state_d = StNorm;
            end
            RadixHex: begin
              buf_d   = load_buf;
              nd_d    = CntW'(DigitsHex);
              state_d = StNorm;
            end
            default: begin
              buf_d   = '0;
              nd_d    = CntW'(DigitsDec);
              state_d = StConv;
            end
          endcase
        end
      end
      StConv: begin
        buf_d  = {bcd_adj[BufW-2:0], val_q[ValW-1]};
        val_d  = val_q << 1;
        iter_d = iter_q + 1'b1;
        if (iter_q == IterW'(ValW - 1)) begin
          state_d = StNorm;
        end
      end
      StNorm: begin
        if ((nd_q > CntW'(1)) && (top_digit(buf_q, radix_q) == 4'd0)) begin
          buf_d = shift_digit(buf_q, radix_q);
          nd_d  = nd_q - 1'b1;
        end else begin
          state_d = StPush;
        end
      end
      StPush: begin
        if (!full_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q        <= val_d;
    buf_q        <= buf_d;
    iter_q       <= iter_d;
    nd_q         <= nd_d;
    radix_q      <= radix_d;
    lc_q         <= lc_d;
    width_q      <= width_d;
    prec_q       <= prec_d;
    prec_given_q <= prec_given_d;
    zero_pad_q   <= zero_pad_d;
    left_q       <= left_d;
    vzero_q      <= vzero_d;
  end

endmodule

// ===== hdl/ipa_queue.sv =====
module ipa_queue import ipa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  localparam int PtrW = $clog2(QDepth);
  localparam int FillW = $clog2(QDepth + 1);

  cmd_t             entry_q [QDepth];
  logic [PtrW-1:0]  wr_q, wr_d;
  logic [PtrW-1:0]  rd_q, rd_d;
  logic [FillW-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == FillW'(QDepth));
  assign empty_o = (fill_q == '0);
  assign cmd_o   = entry_q[rd_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== hdl/ipa_back.sv =====
module ipa_back import ipa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    empty_i,
  input  cmd_t    cmd_i,
  output logic    pop_o,
  output logic    result_valid_o,
  output result_t result_o
);

  logic            active_q, active_d;
  logic [BufW-1:0] buf_q, buf_d;
  radix_e          radix_q, radix_d;
  logic            lc_q, lc_d;
  logic [CntW-1:0] lead_q, lead_d;
  logic [CntW-1:0] zer_q, zer_d;
  logic [CntW-1:0] dig_q, dig_d;
  logic [CntW-1:0] trail_q, trail_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic            valid_q, valid_d;
  result_t         res_q, res_d;
  logic [CntW-1:0] total;

  assign pop_o = !active_q && !empty_i;
  assign total = cmd_i.num_spaces + cmd_i.num_zeros + cmd_i.num_digits;

  // Emit one beat per cycle: leading spaces, zeros, digits, trailing spaces
  always_comb begin
    active_d = active_q;
    buf_d    = buf_q;
    radix_d  = radix_q;
    lc_d     = lc_q;
    lead_d   = lead_q;
    zer_d    = zer_q;
    dig_d    = dig_q;
    trail_d  = trail_q;
    rem_d    = rem_q;
    valid_d  = 1'b0;
    res_d    = res_q;
    if (pop_o) begin
      buf_d    = cmd_i.digits;
      radix_d  = cmd_i.radix;
      lc_d     = cmd_i.lowercase;
      lead_d   = cmd_i.left_align ? '0 : cmd_i.num_spaces;
      trail_d  = cmd_i.left_align ? cmd_i.num_spaces : '0;
      zer_d    = cmd_i.num_zeros;
      dig_d    = cmd_i.num_digits;
      rem_d    = total;
      active_d = (total != '0);
    end else if (active_q) begin
      valid_d         = 1'b1;
      res_d.last_char = (rem_q == CntW'(1));
      rem_d           = rem_q - 1'b1;
      active_d        = (rem_q != CntW'(1));
      if (lead_q != '0) begin
        res_d.out_char = ChSpace;
        lead_d         = lead_q - 1'b1;
      end else if (zer_q != '0) begin
        res_d.out_char = ChZero;
        zer_d          = zer_q - 1'b1;
      end else if (dig_q != '0) begin
        res_d.out_char = digit_char(top_digit(buf_q, radix_q), lc_q);
        buf_d          = shift_digit(buf_q, radix_q);
        dig_d          = dig_q - 1'b1;
      end else begin
        res_d.out_char = ChSpace;
        trail_d        = trail_q - 1'b1;
      end
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q   <= buf_d;
    radix_q <= radix_d;
    lc_q    <= lc_d;
    lead_q  <= lead_d;
    zer_q   <= zer_d;
    dig_q   <= dig_d;
    trail_q <= trail_d;
    rem_q   <= rem_d;
    res_q   <= res_d;
  end

endmodule

// ===== hdl/ipa_checker.sv =====
module ipa_checker import ipa_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input logic    result_valid_o,
  input result_t result_o
);

  logic            seen_q;
  logic [CntW-1:0] chars_q;

  // Track whether any item was taken and the beats of the current item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= 1'b0;
      chars_q <= '0;
    end else begin
      if (start && !busy) begin
        seen_q <= 1'b1;
      end
      if (result_valid_o) begin
        chars_q <= result_o.last_char ? '0 : chars_q + 1'b1;
      end
    end
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted item");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> seen_q)
    else $error("result beat before any item");

  a_max_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (chars_q < CntW'(MaxChars)))
    else $error("item produced too many characters");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      ((result_o.out_char == ChSpace) ||
       ((result_o.out_char >= ChZero) && (result_o.out_char <= ChNine)) ||
       ((result_o.out_char >= ChUpperA) && (result_o.out_char <= ChUpperF)) ||
       ((result_o.out_char >= ChLowerA) && (result_o.out_char <= ChLowerF))))
    else $error("illegal output character");

endmodule

bind integer_to_padded_ascii_core ipa_checker u_ipa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
